/* sv/halton_2d_point_generator_defines.svh */
// ----------------------------------------------------------------------------
// halton_2d_point_generator_defines
// assertion macros shared by the halton point generator rtl
// ----------------------------------------------------------------------------
`ifndef HALTON_2D_POINT_GENERATOR_DEFINES_SVH
`define HALTON_2D_POINT_GENERATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HAL2D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HAL2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/hal2d_pkg.sv */
// ----------------------------------------------------------------------------
// hal2d_pkg
// shared constants for the halton point generator
// ----------------------------------------------------------------------------
package hal2d_pkg;

    // default widths
    localparam int INDEX_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 24;

    // radix width, reset value and minimum
    localparam int             BASE_W     = 8;
    localparam logic [BASE_W-1:0] BASE_RESET = 8'd3;
    localparam logic [BASE_W-1:0] BASE_MIN   = 8'd2;

    // register map
    localparam int         ADDR_W           = 3;
    localparam logic [ADDR_W-1:0] ADDR_SECOND_BASE = 3'd0;

endpackage

/* sv/hal2d_div_cell.sv */
// ----------------------------------------------------------------------------
// hal2d_div_cell
// one restoring step of index / radix, registered toward the next cell
// ----------------------------------------------------------------------------
module hal2d_div_cell #(
    parameter int IDX_BITS = hal2d_pkg::INDEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic [hal2d_pkg::BASE_W-1:0]  divisor_in,
    input  logic [hal2d_pkg::BASE_W-1:0]  rem_in,
    input  logic [IDX_BITS-1:0]           dvd_in,
    input  logic [IDX_BITS-1:0]           quo_in,
    output logic                          valid_out,
    output logic [hal2d_pkg::BASE_W-1:0]  divisor_out,
    output logic [hal2d_pkg::BASE_W-1:0]  rem_out,
    output logic [IDX_BITS-1:0]           dvd_out,
    output logic [IDX_BITS-1:0]           quo_out
);

    logic                          valid_reg;
    logic [hal2d_pkg::BASE_W-1:0]  divisor_reg;
    logic [hal2d_pkg::BASE_W-1:0]  rem_reg;
    logic [IDX_BITS-1:0]           dvd_reg;
    logic [IDX_BITS-1:0]           quo_reg;

    logic [hal2d_pkg::BASE_W:0]    trial;
    logic                          fits;
    logic [hal2d_pkg::BASE_W:0]    diff;
    logic [hal2d_pkg::BASE_W-1:0]  rem_next;
    logic [IDX_BITS-1:0]           dvd_next;
    logic [IDX_BITS-1:0]           quo_next;

    // bring down the next dividend bit and try the subtract
    always_comb
    begin
        trial    = {rem_in, dvd_in[IDX_BITS-1]};
        fits     = (trial >= {1'b0, divisor_in});
        diff     = trial - {1'b0, divisor_in};
        rem_next = fits ? diff[hal2d_pkg::BASE_W-1:0] : trial[hal2d_pkg::BASE_W-1:0];
        dvd_next = {dvd_in[IDX_BITS-2:0], 1'b0};
        quo_next = {quo_in[IDX_BITS-2:0], fits};
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // payload toward the neighbor
    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_in;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        quo_reg     <= quo_next;
    end

    assign valid_out   = valid_reg;
    assign divisor_out = divisor_reg;
    assign rem_out     = rem_reg;
    assign dvd_out     = dvd_reg;
    assign quo_out     = quo_reg;

endmodule

/* sv/halton_2d_point_generator.sv */
// ----------------------------------------------------------------------------
// halton_2d_point_generator
// 2d halton point: base-2 and base-p radical inverse as Q0.FRAC_BITS
// ----------------------------------------------------------------------------
// usage
// - input channel in_valid/in_ready carries sample_index; output channel
//   out_valid/out_ready carries x_coord and y_coord, one transaction each
// - second_base sits at apb address 0; write it only while the block is idle
// - one item is worked at a time: in_ready is high only between items
// - the base-p digits come from a row of INDEX_BITS divider cells; each digit
//   passes through the whole of that row
// - the fraction is then built by long division, one bit per cycle
// - an index of zero has no base-p digits and goes straight to the long division
// - the result waits in an output register; the next item is accepted while
//   it waits, and a full register on a stalled receiver holds the finished
//   value back until out_ready
// - reset clears all control state and sets second_base to 3
// ----------------------------------------------------------------------------
`include "halton_2d_point_generator_defines.svh"

module halton_2d_point_generator #(
    parameter int INDEX_BITS = hal2d_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = hal2d_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // apb configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hal2d_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [23:0]                  sample_index,
    // output channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [23:0]                  x_coord,
    output logic [23:0]                  y_coord
);

    localparam int BW    = hal2d_pkg::BASE_W;
    localparam int DW    = INDEX_BITS + BW + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 2);
    localparam int XB    = (INDEX_BITS < FRAC_BITS) ? INDEX_BITS : FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_LDIV,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [BW-1:0]          base_reg, base_next;
    logic [BW-1:0]          p_reg, p_next;
    logic [INDEX_BITS-1:0]  j_reg, j_next;
    logic [DW-1:0]          num_reg, num_next;
    logic [DW-1:0]          den_reg, den_next;
    logic [DW:0]            rem_reg, rem_next;
    logic [FRAC_BITS:0]     q_reg, q_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [FRAC_BITS-1:0]   x_reg, x_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FRAC_BITS-1:0]   x_out_reg, x_out_next;
    logic [FRAC_BITS-1:0]   y_out_reg, y_out_next;

    logic                   cfg_write;
    logic                   in_fire;
    logic [INDEX_BITS-1:0]  idx;
    logic [FRAC_BITS-1:0]   x_rev;
    logic [DW-1:0]          p_ext;
    logic [DW-1:0]          num_mul;
    logic [DW-1:0]          den_mul;
    logic [DW:0]            rem_shift;
    logic [FRAC_BITS+1:0]   q_inc;
    logic [FRAC_BITS:0]     q_rnd;
    logic [FRAC_BITS-1:0]   y_sat;

    // divider row
    logic                   c_valid [0:INDEX_BITS];
    logic [BW-1:0]          c_div   [0:INDEX_BITS];
    logic [BW-1:0]          c_rem   [0:INDEX_BITS];
    logic [INDEX_BITS-1:0]  c_dvd   [0:INDEX_BITS];
    logic [INDEX_BITS-1:0]  c_quo   [0:INDEX_BITS];

    assign c_valid[0] = (state_reg == S_ISSUE);
    assign c_div[0]   = p_reg;
    assign c_rem[0]   = '0;
    assign c_dvd[0]   = j_reg;
    assign c_quo[0]   = '0;

    for (genvar g = 0; g < INDEX_BITS; g++)
    begin : g_cell
        hal2d_div_cell #(
            .IDX_BITS (INDEX_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .valid_in    (c_valid[g]),
            .divisor_in  (c_div[g]),
            .rem_in      (c_rem[g]),
            .dvd_in      (c_dvd[g]),
            .quo_in      (c_quo[g]),
            .valid_out   (c_valid[g+1]),
            .divisor_out (c_div[g+1]),
            .rem_out     (c_rem[g+1]),
            .dvd_out     (c_dvd[g+1]),
            .quo_out     (c_quo[g+1])
        );
    end

    // apb port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == hal2d_pkg::ADDR_SECOND_BASE);
    assign prdata    = (paddr == hal2d_pkg::ADDR_SECOND_BASE) ? {{(32-BW){1'b0}}, base_reg}
                                                              : 32'd0;

    // handshake
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign idx      = INDEX_BITS'(sample_index);

    // base-2 radical inverse: mirror the index bits
    always_comb
    begin
        x_rev = '0;
        for (int k = 0; k < XB; k++)
        begin
            x_rev[FRAC_BITS-1-k] = idx[k];
        end
    end

    // digit accumulation and fraction rounding
    assign p_ext     = {{(DW-BW){1'b0}}, p_reg};
    assign num_mul   = DW'(num_reg * p_ext);
    assign den_mul   = DW'(den_reg * p_ext);
    assign rem_shift = {rem_reg[DW-1:0], 1'b0};
    assign q_inc     = {1'b0, q_reg} + (FRAC_BITS+2)'(1);
    assign q_rnd     = q_inc[FRAC_BITS+1:1];
    assign y_sat     = q_rnd[FRAC_BITS] ? {FRAC_BITS{1'b1}} : q_rnd[FRAC_BITS-1:0];

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        p_next         = p_reg;
        j_next         = j_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        out_valid_next = out_valid_reg;
        x_out_next     = x_out_reg;
        y_out_next     = y_out_reg;

        if (cfg_write)
        begin
            base_next = pwdata[BW-1:0];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    p_next   = (base_reg < hal2d_pkg::BASE_MIN) ? hal2d_pkg::BASE_MIN
                                                                : base_reg;
                    j_next   = idx;
                    num_next = '0;
                    den_next = DW'(1);
                    x_next   = x_rev;
                    rem_next = '0;
                    q_next   = '0;
                    cnt_next = '0;
                    state_next = (idx == '0) ? S_LDIV : S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (c_valid[INDEX_BITS])
                begin
                    num_next = num_mul + {{(DW-BW){1'b0}}, c_rem[INDEX_BITS]};
                    den_next = den_mul;
                    j_next   = c_quo[INDEX_BITS];
                    if (c_quo[INDEX_BITS] == '0)
                    begin
                        rem_next   = {1'b0, num_next};
                        state_next = S_LDIV;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_LDIV:
            begin
                if (rem_shift >= {1'b0, den_reg})
                begin
                    rem_next = rem_shift - {1'b0, den_reg};
                    q_next   = {q_reg[FRAC_BITS-1:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift;
                    q_next   = {q_reg[FRAC_BITS-1:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    x_out_next     = x_reg;
                    y_out_next     = y_sat;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= hal2d_pkg::BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        j_reg     <= j_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        x_reg     <= x_next;
        x_out_reg <= x_out_next;
        y_out_reg <= y_out_next;
    end

    assign out_valid = out_valid_reg;
    assign x_coord   = 24'(x_out_reg);
    assign y_coord   = 24'(y_out_reg);

    // checks
    `HAL2D_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != S_IDLE,
        "accepted transaction did not start work")
    `HAL2D_ASSERT_NOW(a_row_only_when_waiting, c_valid[INDEX_BITS], state_reg == S_WAIT,
        "divider row result arrived outside the wait state")
    `HAL2D_ASSERT_NOW(a_row_divisor_kept, c_valid[INDEX_BITS], c_div[INDEX_BITS] == p_reg,
        "divider row carried a stale radix")
    `HAL2D_ASSERT_NOW(a_row_drained, c_valid[INDEX_BITS], c_dvd[INDEX_BITS] == '0,
        "divider row left dividend bits unused")
    `HAL2D_ASSERT_NOW(a_ldiv_rem_below_den, state_reg == S_LDIV, rem_reg < {1'b0, den_reg},
        "long division remainder not below denominator")

endmodule
